@@ rtl/iprt_pkg.sv @@
package iprt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int DEVICE_MAX = 15;
   localparam int LEVEL_LEN_SHIFT = 24;
   localparam int ADDR_BITS = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_DOWN   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EXISTS   = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] dest_ip;
      logic [5:0]  prefix_len;
      logic [31:0] gateway;
      logic [3:0]  device;
      logic [31:0] src_ip;
      logic [15:0] metric;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] route_dst;
      logic [5:0]  route_prefix_len;
      logic [31:0] route_gateway;
      logic [3:0]  route_device;
      logic [31:0] route_src;
      logic [15:0] route_metric;
      logic [31:0] next_hop;
      logic [4:0]  removed_count;
      logic [4:0]  entry_count;
      logic [31:0] change_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] dst;
      logic [5:0]  prefix_len;
      logic [31:0] gateway;
      logic [3:0]  device;
      logic [31:0] src;
      logic [15:0] metric;
   } entry_type;

   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
   } sts_type;

endpackage

@@ rtl/iprt_ram.sv @@
module iprt_ram import iprt_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/iprt_ctrl.sv @@
module iprt_ctrl import iprt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_end) begin
               cmd.finish = 1'b1;
               state_in   = S_RESP;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_finish_once: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !cmd.finish && rsp_valid)
      else $error("finish not followed by response");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.start && rsp_valid))
      else $error("request taken while response pending");

endmodule

@@ rtl/iprt_dp.sv @@
module iprt_dp import iprt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int UW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
   localparam int EW = $bits(entry_type);

   req_type   q_ff;
   logic      bad_ff;
   logic [UW-1:0] rd_ff, rd_in, wr_ff, wr_in, rem_ff, rem_in, used_ff, used_in;
   logic      rd_vld_ff, rd_vld_in, found_ff, found_in;
   logic [31:0] best_ff, best_in, chg_ff, chg_in;
   entry_type win_ff, win_in;
   rsp_type   rsp_ff, rsp_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   entry_type     wdata, e;
   logic [EW-1:0] rdata;

   logic [UW-1:0] used_eff;
   logic          dup, pfx_hit, dev_hit, bad_now;
   logic [31:0]   pmask, lvl;
   entry_type     q_entry;

   iprt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign e = entry_type'(rdata);
   assign q_entry = '{dst: q_ff.dest_ip, prefix_len: q_ff.prefix_len, gateway: q_ff.gateway,
                      device: q_ff.device, src: q_ff.src_ip, metric: q_ff.metric};
   assign used_eff = bad_ff ? '0 : used_ff;
   assign sts.scan_end = (rd_ff >= used_eff) && !rd_vld_ff;
   assign bad_now = ({4'b0, req_data.device} > 8'(DEVICE_MAX)) ||
                    ((req_data.operation == OP_ADD) &&
                     ((req_data.prefix_len > 6'(ADDR_BITS)) || (req_data.device == 4'd0)));

   // zero stored field other than dst is a wildcard
   assign dup = (e.dst == q_ff.dest_ip) &&
                ((e.gateway == 32'd0) || (e.gateway == q_ff.gateway)) &&
                ((e.prefix_len == 6'd0) || (e.prefix_len == q_ff.prefix_len)) &&
                ((e.device == 4'd0) || (e.device == q_ff.device)) &&
                ((e.src == 32'd0) || (e.src == q_ff.src_ip)) &&
                ((e.metric == 16'd0) || (e.metric == q_ff.metric));
   assign pmask = (e.prefix_len >= 6'(ADDR_BITS)) ? '1 : ~(32'hFFFF_FFFF >> e.prefix_len);
   assign pfx_hit = ((e.dst & pmask) == (q_ff.dest_ip & pmask));
   assign dev_hit = (q_ff.device == 4'd0) || (e.device == q_ff.device);
   assign lvl = {2'b0, e.prefix_len, 7'b0, (e.gateway == 32'd0), ~e.metric};

   always_comb begin
      rd_in     = rd_ff;
      rd_vld_in = 1'b0;
      wr_in     = wr_ff;
      rem_in    = rem_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      win_in    = win_ff;
      used_in   = used_ff;
      chg_in    = chg_ff;
      rsp_in    = rsp_ff;
      we        = 1'b0;
      waddr     = wr_ff[AW-1:0];
      wdata     = e;
      raddr     = rd_ff[AW-1:0];

      if (cmd.start) begin
         rd_in    = '0;
         wr_in    = '0;
         rem_in   = '0;
         found_in = 1'b0;
         best_in  = '0;
      end

      if (cmd.step) begin
         if (rd_ff < used_eff) begin
            rd_vld_in = 1'b1;
            rd_in     = rd_ff + 1'b1;
         end
         if (rd_vld_ff) begin
            case (op_type'(q_ff.operation))
               OP_ADD: begin
                  if (dup) found_in = 1'b1;
               end
               OP_DELETE: begin
                  if (dup && !found_ff) begin
                     found_in = 1'b1;
                     rem_in   = rem_ff + 1'b1;
                  end else begin
                     we    = 1'b1;
                     wr_in = wr_ff + 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  if (pfx_hit && dev_hit && (lvl > best_ff)) begin
                     best_in = lvl;
                     win_in  = e;
                  end
               end
               OP_DOWN: begin
                  if ((q_ff.device != 4'd0) && (e.device == q_ff.device)) begin
                     rem_in = rem_ff + 1'b1;
                  end else begin
                     we    = 1'b1;
                     wr_in = wr_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end

      if (cmd.finish) begin
         rsp_in = '0;
         rsp_in.status = ST_OK;
         if (bad_ff) begin
            rsp_in.status = ST_INVALID;
         end else begin
            case (op_type'(q_ff.operation))
               OP_ADD: begin
                  if (found_ff) begin
                     rsp_in.status = ST_EXISTS;
                  end else if (used_ff >= UW'(TABLE_DEPTH)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     we      = 1'b1;
                     waddr   = used_ff[AW-1:0];
                     wdata   = q_entry;
                     used_in = used_ff + 1'b1;
                     chg_in  = chg_ff + 32'd1;
                  end
               end
               OP_LOOKUP: begin
                  if (best_ff == 32'd0) begin
                     rsp_in.status = ST_NOTFOUND;
                  end else begin
                     rsp_in.route_dst        = win_ff.dst;
                     rsp_in.route_prefix_len = win_ff.prefix_len;
                     rsp_in.route_gateway    = win_ff.gateway;
                     rsp_in.route_device     = win_ff.device;
                     rsp_in.route_src        = win_ff.src;
                     rsp_in.route_metric     = win_ff.metric;
                     rsp_in.next_hop = (win_ff.gateway != 32'd0) ? win_ff.gateway
                                                                  : q_ff.dest_ip;
                  end
               end
               OP_DELETE, OP_DOWN: begin
                  if ((q_ff.operation == OP_DELETE) && !found_ff) begin
                     rsp_in.status = ST_NOTFOUND;
                  end
                  used_in = used_ff - rem_ff;
                  chg_in  = chg_ff + 32'(rem_ff);
               end
               default: ;
            endcase
         end
         rsp_in.removed_count = 5'(rem_ff);
         rsp_in.entry_count   = 5'(used_in);
         rsp_in.change_count  = chg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         chg_ff    <= '0;
         rd_vld_ff <= 1'b0;
         rd_ff     <= '0;
         wr_ff     <= '0;
      end else begin
         used_ff   <= used_in;
         chg_ff    <= chg_in;
         rd_vld_ff <= rd_vld_in;
         rd_ff     <= rd_in;
         wr_ff     <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         q_ff   <= req_data;
         bad_ff <= bad_now;
      end
      rem_ff   <= rem_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      win_ff   <= win_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(TABLE_DEPTH))
      else $error("entry count above depth");
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      wr_ff <= rd_ff)
      else $error("compaction write ahead of read");
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rd_vld_ff)
      else $error("finish with read data pending");

endmodule

@@ rtl/ipv4_route_table_lpm.sv @@
// IPv4 route table with longest-prefix lookup. Routes sit in insertion order in a single
// RAM; every valid request scans the N entries in use one per cycle through the RAM read
// port, and delete / device-down compact the table in place during the same scan. The
// scan issues the N reads, waits for the registered read data of the last one, and then
// a finish step loads the response register; an empty table or an invalid request goes
// straight to the finish step. One request is in flight at a time and the next one can
// be taken in the cycle after the response is taken, so no new request is accepted before
// the previous response has been taken. No clearing pass is needed after reset.
module ipv4_route_table_lpm import iprt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   iprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   iprt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
